@@ hw/rtl/lpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared constants and types for the lru page replacement block.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int MAX_FRAMES     = 16;
    localparam int PAGE_BITS      = 16;
    localparam int PORT_PAGE_BITS = 16;
    localparam int INDEX_BITS     = 4;
    localparam int CFG_BITS       = 5;
    localparam int FAULT_BITS     = 32;
    localparam int FRAME_BITS     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_BITS      = FRAME_BITS;

    localparam logic [CFG_BITS-1:0]   FRAMES_RESET = CFG_BITS'(3);
    localparam logic [RANK_BITS-1:0]  RANK_MAX     = RANK_BITS'(MAX_FRAMES - 1);
    localparam logic [FAULT_BITS-1:0] FAULT_MAX    = {FAULT_BITS{1'b1}};

    typedef logic [MAX_FRAMES-1:0]                 frame_vec_t;
    typedef logic [MAX_FRAMES-1:0][PAGE_BITS-1:0]  page_arr_t;
    typedef logic [MAX_FRAMES-1:0][RANK_BITS-1:0]  rank_arr_t;

    typedef struct packed {
        logic                  hit;
        logic                  fill_empty;
        logic                  evict;
        logic [FRAME_BITS-1:0] idx;
    } lpr_sel_t;

    typedef struct packed {
        logic                      hit;
        logic [INDEX_BITS-1:0]     frame_index;
        logic                      evicted_valid;
        logic [PORT_PAGE_BITS-1:0] evicted_page;
        logic [FAULT_BITS-1:0]     fault_total;
    } lpr_result_t;

endpackage

@@ hw/rtl/lru_page_replacement.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative page frame store with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  channel   signals                                   dir   handshake
//  in        page                                      in    in_valid/in_ready
//  out       hit frame_index evicted_valid             out   out_valid/out_ready
//            evicted_page fault_total
//  cfg       cfg_wr_data (frames_in_use)               in    cfg_wr_en
//
//  one transaction per clock while the output is not stalled; the page is held
//  in the input register and the result in the result register, around the
//  combinational compare, victim pick and rank update
//  reset clears valid bits, ranks, fault count; frames_in_use resets to 3
//  an output stall holds the result and lets one more input sit registered
// ----------------------------------------------------------------------------
module lru_page_replacement
    import lpr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_BITS-1:0]       cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [PORT_PAGE_BITS-1:0] page,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      hit,
    output logic [INDEX_BITS-1:0]     frame_index,
    output logic                      evicted_valid,
    output logic [PORT_PAGE_BITS-1:0] evicted_page,
    output logic [FAULT_BITS-1:0]     fault_total
);

    logic [CFG_BITS-1:0]  frames_in_use_reg;
    logic                 in_full_reg;
    logic                 in_full_next;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    lpr_result_t          result_reg;
    lpr_result_t          result;
    logic                 advance;
    logic                 in_fire;

    assign advance  = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_fire)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    lpr_store u_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .page          (page_reg),
        .frames_in_use (frames_in_use_reg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= FRAMES_RESET;
            in_full_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                frames_in_use_reg <= cfg_wr_data;
            end
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            page_reg <= PAGE_BITS'(page);
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = result_reg.hit;
    assign frame_index   = result_reg.frame_index;
    assign evicted_valid = result_reg.evicted_valid;
    assign evicted_page  = result_reg.evicted_page;
    assign fault_total   = result_reg.fault_total;

endmodule

@@ hw/rtl/lpr_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_lookup
// Parallel tag compare, empty frame search and lru victim pick.
// ----------------------------------------------------------------------------
module lpr_lookup
    import lpr_pkg::*;
(
    input  logic [PAGE_BITS-1:0] page,
    input  page_arr_t            frame_page,
    input  frame_vec_t           frame_valid,
    input  rank_arr_t            recency_rank,
    input  frame_vec_t           active,
    output lpr_sel_t             sel
);

    frame_vec_t            hit_vec;
    frame_vec_t            empty_vec;
    frame_vec_t            max_vec;
    logic [FRAME_BITS-1:0] hit_idx;
    logic [FRAME_BITS-1:0] empty_idx;
    logic [FRAME_BITS-1:0] max_idx;

    always_comb
    begin
        for (int j = 0; j < MAX_FRAMES; j++)
        begin
            hit_vec[j]   = active[j] & frame_valid[j] & (frame_page[j] == page);
            empty_vec[j] = active[j] & ~frame_valid[j];
            max_vec[j]   = active[j];
            for (int k = 0; k < MAX_FRAMES; k++)
            begin
                if (active[k] && (recency_rank[k] > recency_rank[j]))
                begin
                    max_vec[j] = 1'b0;
                end
            end
        end
    end

    // lowest set index of each vector
    always_comb
    begin
        hit_idx   = '0;
        empty_idx = '0;
        max_idx   = '0;
        for (int j = MAX_FRAMES - 1; j >= 0; j--)
        begin
            if (hit_vec[j])
            begin
                hit_idx = FRAME_BITS'(j);
            end
            if (empty_vec[j])
            begin
                empty_idx = FRAME_BITS'(j);
            end
            if (max_vec[j])
            begin
                max_idx = FRAME_BITS'(j);
            end
        end
    end

    always_comb
    begin
        sel.hit        = |hit_vec;
        sel.fill_empty = ~(|hit_vec) & (|empty_vec);
        sel.evict      = ~(|hit_vec) & ~(|empty_vec);
        if (|hit_vec)
        begin
            sel.idx = hit_idx;
        end
        else if (|empty_vec)
        begin
            sel.idx = empty_idx;
        end
        else
        begin
            sel.idx = max_idx;
        end
    end

endmodule

@@ hw/rtl/lpr_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_store
// Frame tags, valid bits, recency ranks and fault counter with their update.
// ----------------------------------------------------------------------------
module lpr_store
    import lpr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [PAGE_BITS-1:0] page,
    input  logic [CFG_BITS-1:0] frames_in_use,
    output lpr_result_t         result
);

    page_arr_t             frame_page_reg;
    frame_vec_t            frame_valid_reg;
    rank_arr_t             recency_rank_reg;
    rank_arr_t             recency_rank_next;
    logic [FAULT_BITS-1:0] fault_count_reg;
    logic [FAULT_BITS-1:0] fault_count_next;
    frame_vec_t            active;
    lpr_sel_t              sel;
    logic [RANK_BITS-1:0]  limit;

    // frame 0 always takes part, the rest up to the configured count
    always_comb
    begin
        for (int j = 0; j < MAX_FRAMES; j++)
        begin
            active[j] = (j == 0) || (32'(frames_in_use) > 32'(j));
        end
    end

    lpr_lookup u_lookup (
        .page         (page),
        .frame_page   (frame_page_reg),
        .frame_valid  (frame_valid_reg),
        .recency_rank (recency_rank_reg),
        .active       (active),
        .sel          (sel)
    );

    assign limit = recency_rank_reg[sel.idx];

    always_comb
    begin
        for (int j = 0; j < MAX_FRAMES; j++)
        begin
            recency_rank_next[j] = recency_rank_reg[j];
            if (FRAME_BITS'(j) == sel.idx)
            begin
                recency_rank_next[j] = '0;
            end
            else if (active[j] && frame_valid_reg[j]
                     && (sel.fill_empty || (recency_rank_reg[j] < limit))
                     && (recency_rank_reg[j] < RANK_MAX))
            begin
                recency_rank_next[j] = recency_rank_reg[j] + RANK_BITS'(1);
            end
        end
    end

    always_comb
    begin
        fault_count_next = fault_count_reg;
        if (!sel.hit && (fault_count_reg != FAULT_MAX))
        begin
            fault_count_next = fault_count_reg + FAULT_BITS'(1);
        end
    end

    always_comb
    begin
        result.hit           = sel.hit;
        result.frame_index   = INDEX_BITS'(sel.idx);
        result.evicted_valid = sel.evict;
        result.evicted_page  = sel.evict ? PORT_PAGE_BITS'(frame_page_reg[sel.idx]) : '0;
        result.fault_total   = fault_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg  <= '0;
            recency_rank_reg <= '0;
            fault_count_reg  <= '0;
        end
        else if (fire)
        begin
            recency_rank_reg <= recency_rank_next;
            fault_count_reg  <= fault_count_next;
            if (!sel.hit)
            begin
                frame_valid_reg[sel.idx] <= 1'b1;
            end
        end
    end

    // tags need no reset, valid bits guard them
    always_ff @(posedge clk)
    begin
        if (fire && !sel.hit)
        begin
            frame_page_reg[sel.idx] <= page;
        end
    end

endmodule

@@ hw/rtl/lpr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_checker
// Port-level checks on the lru page replacement result stream.
// ----------------------------------------------------------------------------
module lpr_checker
    import lpr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic                      hit,
    input  logic                      evicted_valid,
    input  logic [PORT_PAGE_BITS-1:0] evicted_page,
    input  logic [FAULT_BITS-1:0]     fault_total
);

    logic                  prev_seen_reg;
    logic [FAULT_BITS-1:0] prev_fault_reg;
    logic                  out_fire;

    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_seen_reg  <= 1'b0;
            prev_fault_reg <= '0;
        end
        else if (out_fire)
        begin
            prev_seen_reg  <= 1'b1;
            prev_fault_reg <= fault_total;
        end
    end

    // stalled result stays presented
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !evicted_valid)
        else $error("eviction reported on a hit");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted_valid |-> evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    // fault count holds on hits and steps by one on faults until full
    assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && prev_seen_reg |->
            (hit && fault_total == prev_fault_reg)
            || (!hit && prev_fault_reg == FAULT_MAX && fault_total == FAULT_MAX)
            || (!hit && prev_fault_reg != FAULT_MAX
                && fault_total == prev_fault_reg + FAULT_BITS'(1)))
        else $error("fault total out of sequence");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lru page replacement block. A directed pass
// covers page extremes, the frame-count corner cases, duplicate resident
// pages and tied eviction ranks. Random phases then run under several
// frame-count settings, followed by a long output stall. Every result is
// checked field by field against a behavioral model of the frame store.
// ----------------------------------------------------------------------------
module testbench;
    import lpr_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS = 200;
    localparam int POOL_DEPTH  = 40;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_BITS-1:0]       cfg_wr_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [PORT_PAGE_BITS-1:0] page = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      hit;
    logic [INDEX_BITS-1:0]     frame_index;
    logic                      evicted_valid;
    logic [PORT_PAGE_BITS-1:0] evicted_page;
    logic [FAULT_BITS-1:0]     fault_total;

    // model of the frame store
    logic [PAGE_BITS-1:0]      model_page [MAX_FRAMES];
    bit                        model_valid [MAX_FRAMES];
    int unsigned               model_rank [MAX_FRAMES];
    logic [FAULT_BITS-1:0]     model_faults = '0;
    logic [CFG_BITS-1:0]       model_frames = FRAMES_RESET;

    lpr_result_t               pending_results [$];
    lpr_result_t               want_result;
    logic [PORT_PAGE_BITS-1:0] page_pool [POOL_DEPTH];

    int   errors = 0;
    int   n_access = 0;
    int   n_hits = 0;
    int   n_evicts = 0;
    int   n_settings = 0;
    int   idle_cycles = 0;
    bit   quiet = 1'b0;
    bit   hold_active = 1'b0;
    event hold_off_ev;

    lru_page_replacement dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .page          (page),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

    always #5 clk = ~clk;

    function automatic int frames_active(input logic [CFG_BITS-1:0] setting);
        if (setting == 0)
            return 1;
        if (setting > MAX_FRAMES)
            return MAX_FRAMES;
        return int'(setting);
    endfunction

    function automatic void age_frames(input int n, input int sel, input int unsigned limit);
        for (int j = 0; j < n; j++)
        begin
            if (j != sel && model_valid[j] && model_rank[j] < limit &&
                model_rank[j] < MAX_FRAMES - 1)
                model_rank[j]++;
        end
        model_rank[sel] = 0;
    endfunction

    function automatic lpr_result_t lru_lookup(input logic [PORT_PAGE_BITS-1:0] pg);
        lpr_result_t r;
        int          n;
        int          sel;
        int unsigned best;
        bit          found;
        bit          empty;
        r     = '0;
        n     = frames_active(model_frames);
        sel   = 0;
        found = 1'b0;
        empty = 1'b0;
        for (int j = 0; j < n; j++)
        begin
            if (!found && model_valid[j] && model_page[j] == pg[PAGE_BITS-1:0])
            begin
                sel   = j;
                found = 1'b1;
            end
        end
        if (found)
            age_frames(n, sel, model_rank[sel]);
        else
        begin
            if (model_faults != FAULT_MAX)
                model_faults++;
            for (int j = 0; j < n; j++)
            begin
                if (!empty && !model_valid[j])
                begin
                    sel   = j;
                    empty = 1'b1;
                end
            end
            if (empty)
            begin
                model_valid[sel] = 1'b1;
                model_page[sel]  = pg[PAGE_BITS-1:0];
                age_frames(n, sel, 32'hFFFF_FFFF);
            end
            else
            begin
                best = 0;
                sel  = 0;
                for (int j = 0; j < n; j++)
                begin
                    if (model_rank[j] > best)
                    begin
                        best = model_rank[j];
                        sel  = j;
                    end
                end
                r.evicted_valid = 1'b1;
                r.evicted_page  = PORT_PAGE_BITS'(model_page[sel]);
                model_page[sel] = pg[PAGE_BITS-1:0];
                age_frames(n, sel, best);
            end
        end
        r.hit         = found;
        r.frame_index = INDEX_BITS'(sel);
        r.fault_total = model_faults;
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no access outstanding, frame_index %0d",
                       frame_index);
                errors++;
            end
            else
            begin
                want_result = pending_results.pop_front();
                if (hit !== want_result.hit)
                begin
                    $error("hit: expected %0d, actual %0d", want_result.hit, hit);
                    errors++;
                end
                if (frame_index !== want_result.frame_index)
                begin
                    $error("frame_index: expected %0d, actual %0d",
                           want_result.frame_index, frame_index);
                    errors++;
                end
                if (evicted_valid !== want_result.evicted_valid)
                begin
                    $error("evicted_valid: expected %0d, actual %0d",
                           want_result.evicted_valid, evicted_valid);
                    errors++;
                end
                if (evicted_page !== want_result.evicted_page)
                begin
                    $error("evicted_page: expected 0x%04h, actual 0x%04h",
                           want_result.evicted_page, evicted_page);
                    errors++;
                end
                if (fault_total !== want_result.fault_total)
                begin
                    $error("fault_total: expected %0d, actual %0d",
                           want_result.fault_total, fault_total);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver
    always @(negedge clk)
        out_ready <= hold_active ? 1'b0 : (quiet || $urandom_range(99) >= 6);

    always
    begin
        @(hold_off_ev);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active = 1'b0;
    end

    task automatic send_access(input logic [PORT_PAGE_BITS-1:0] pg);
        lpr_result_t r;
        while (!quiet && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        page     <= pg;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        r = lru_lookup(pg);
        pending_results.push_back(r);
        n_access++;
        if (r.hit)
            n_hits++;
        if (r.evicted_valid)
            n_evicts++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_frames(input logic [CFG_BITS-1:0] setting);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= setting;
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
        model_frames = setting;
        n_settings++;
    endtask

    task automatic test_directed();
        // reset setting of three frames: fill, hit, evict
        send_access(16'h0000);
        send_access(16'hFFFF);
        send_access(16'h0000);
        send_access(16'h8001);
        send_access(16'h7FFE);
        send_access(16'h0000);
        // zero acts as one frame
        set_frames(5'd0);
        send_access(16'h1111);
        send_access(16'h1111);
        send_access(16'h2222);
        // above the maximum acts as all frames
        set_frames(5'd31);
        send_access(16'h7FFE);
        send_access(16'h3333);
        // same page resident twice, lowest frame wins
        set_frames(5'd1);
        send_access(16'h8001);
        set_frames(5'd31);
        send_access(16'h8001);
        // equal ranks at eviction
        set_frames(5'd2);
        send_access(16'h7FFE);
        set_frames(5'd1);
        send_access(16'h4444);
        set_frames(5'd2);
        send_access(16'hBBBB);
        set_frames(5'd17);
        send_access(16'hFFFF);
        send_access(16'h0001);
    endtask

    task automatic run_phase(input logic [CFG_BITS-1:0] setting, input int count);
        int                        n;
        int                        pool_size;
        logic [PORT_PAGE_BITS-1:0] pg;
        set_frames(setting);
        n         = frames_active(setting);
        pool_size = n + $urandom_range(1, n + 3);
        for (int i = 0; i < pool_size; i++)
            page_pool[i] = PORT_PAGE_BITS'($urandom());
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(19))
                0:       pg = '0;
                1:       pg = '1;
                2, 3:    pg = PORT_PAGE_BITS'($urandom());
                default: pg = page_pool[$urandom_range(pool_size - 1)];
            endcase
            send_access(pg);
        end
    endtask

    task automatic test_random_phases();
        logic [CFG_BITS-1:0] settings [8];
        settings = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd4, 5'd9, 5'd16};
        settings[5] = CFG_BITS'($urandom_range(31));
        settings[6] = CFG_BITS'($urandom_range(31));
        for (int i = 0; i < 8; i++)
        begin
            quiet = (i == 0);
            run_phase(settings[i], PHASE_ITEMS);
        end
        quiet = 1'b0;
    endtask

    task automatic test_output_stall();
        -> hold_off_ev;
        for (int i = 0; i < 40; i++)
            send_access(page_pool[$urandom_range(7)]);
        drain();
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random_phases();
        test_output_stall();
        drain();
        repeat (10) @(negedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        $display("covered %0d accesses over %0d frame-count settings (0, 1, 16, 17, 31 included)",
                 n_access, n_settings);
        $display("saw %0d hits, %0d faults, %0d evictions and a %0d-cycle output stall",
                 n_hits, model_faults, n_evicts, HOLD_CYCLES);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
